FILE: hdl/mgc_pkg.sv
// Shared types, constants and gear table for the multilevel gear chunker.
`timescale 1ns / 1ps

package mgc_pkg;

  localparam int POSITION_BITS = 48;
  localparam int LENGTH_BITS = 16;
  localparam int HASH_BITS = 32;
  localparam int CFG_BITS = 16;
  localparam int CFG_INDEX_BITS = 3;
  localparam int MASK_BITS = 13;
  localparam int GEAR_ENTRIES = 192;

  localparam logic [MASK_BITS-1:0] MICRO_MASK = 13'h00FF;
  localparam logic [MASK_BITS-1:0] SMALL_SHORT = 13'h03FF;
  localparam logic [MASK_BITS-1:0] SMALL_LONG = 13'h07FF;
  localparam logic [MASK_BITS-1:0] NORMAL_SHORT = 13'h07FF;
  localparam logic [MASK_BITS-1:0] NORMAL_LONG = 13'h0FFF;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MICRO_MIN  = 3'd0,
    REG_MICRO_AVG  = 3'd1,
    REG_SMALL_MIN  = 3'd2,
    REG_SMALL_AVG  = 3'd3,
    REG_NORMAL_MIN = 3'd4,
    REG_NORMAL_AVG = 3'd5,
    REG_MAX_LENGTH = 3'd6
  } cfg_index_t;

  typedef enum logic [1:0] {
    LEVEL_MICRO  = 2'd0,
    LEVEL_SMALL  = 2'd1,
    LEVEL_NORMAL = 2'd2
  } level_t;

  typedef enum logic [1:0] {
    REASON_HASH = 2'd0,
    REASON_MAX  = 2'd1,
    REASON_EOD  = 2'd2
  } reason_t;

  typedef logic [LENGTH_BITS-1:0] length_t;
  typedef logic [POSITION_BITS-1:0] position_t;
  typedef logic [HASH_BITS-1:0] hash_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [47:0] chunk_start;
    logic [15:0] chunk_length;
    level_t      chunk_level;
    reason_t     cut_reason;
  } out_word_t;

  typedef struct packed {
    logic [CFG_BITS-1:0] micro_min_length;
    logic [CFG_BITS-1:0] micro_avg_length;
    logic [CFG_BITS-1:0] small_min_length;
    logic [CFG_BITS-1:0] small_avg_length;
    logic [CFG_BITS-1:0] normal_min_length;
    logic [CFG_BITS-1:0] normal_avg_length;
    logic [CFG_BITS-1:0] max_length;
  } cfg_regs_t;

  typedef struct packed {
    logic    cut;
    level_t  level;
    reason_t reason;
  } cut_dec_t;

  // bytes 192..255 have no entry here and look up as zero
  localparam logic [31:0] GEAR_VALUES [GEAR_ENTRIES] = '{
    32'h67ed26b7, 32'h32da500f, 32'h53d0fee3, 32'hce620efb,
    32'hd4c8c93c, 32'hc6f250bb, 32'h30ddc3e8, 32'ha2a8515e,
    32'h3bc9bd50, 32'h4b136f67, 32'h67a3b0c9, 32'h42f66ef8,
    32'hf0842d0d, 32'hdc56c4e5, 32'h7b8b26b7, 32'h8c8ca762,
    32'hb0e7b346, 32'h2482fb41, 32'h7e315179, 32'h27ff677e,
    32'hf8d0dc3f, 32'h49d4b519, 32'h64b0f3a1, 32'h8fe3b520,
    32'hf4ef00a3, 32'h2c2f8f2d, 32'h2b41b5c7, 32'h2d7e4a6e,
    32'h89f4c7c8, 32'h9f49ff7e, 32'h9e847c80, 32'h3c9e96cb,
    32'h7c7f9df6, 32'h4ff61e9f, 32'h3d3e7e41, 32'h6e2d4e27,
    32'h0e3f4c30, 32'hf2c4c8f3, 32'h3f13e0e6, 32'h4d73aaf9,
    32'h3d3e8444, 32'h5e8e6c8c, 32'ha3e8e8c0, 32'hd3b1c3c7,
    32'h8a8c8484, 32'he3c0c0c0, 32'h8c8c8c8c, 32'hc0c0c0c0,
    32'h1e6e6e6e, 32'h7a7a7a7a, 32'h4f4f4f4f, 32'hb3b3b3b3,
    32'h26262626, 32'h9a9a9a9a, 32'h5d5d5d5d, 32'he1e1e1e1,
    32'h38383838, 32'h8c8c8c8c, 32'h70707070, 32'hc4c4c4c4,
    32'h19191919, 32'h6d6d6d6d, 32'ha1a1a1a1, 32'hd5d5d5d5,
    32'h2a2a2a2a, 32'h7e7e7e7e, 32'hb2b2b2b2, 32'he6e6e6e6,
    32'h3b3b3b3b, 32'h8f8f8f8f, 32'hc3c3c3c3, 32'hf7f7f7f7,
    32'h4c4c4c4c, 32'h90909090, 32'hd4d4d4d4, 32'h18181818,
    32'h5c5c5c5c, 32'ha0a0a0a0, 32'he4e4e4e4, 32'h28282828,
    32'h6c6c6c6c, 32'hb0b0b0b0, 32'hf4f4f4f4, 32'h39393939,
    32'h7d7d7d7d, 32'hc1c1c1c1, 32'h05050505, 32'h49494949,
    32'h8d8d8d8d, 32'hd1d1d1d1, 32'h16161616, 32'h5a5a5a5a,
    32'h9e9e9e9e, 32'he2e2e2e2, 32'h27272727, 32'h6b6b6b6b,
    32'hafafafaf, 32'hf3f3f3f3, 32'h37373737, 32'h7b7b7b7b,
    32'hbfbfbfbf, 32'h03030303, 32'h47474747, 32'h8b8b8b8b,
    32'hcfcfcfcf, 32'h13131313, 32'h57575757, 32'h9b9b9b9b,
    32'hdfdfdfdf, 32'h23232323, 32'h67676767, 32'habababab,
    32'hefefefef, 32'h33333333, 32'h77777777, 32'hbbbbbbbb,
    32'hffffffff, 32'h43434343, 32'h87878787, 32'hcbcbcbcb,
    32'h0f0f0f0f, 32'h53535353, 32'h97979797, 32'hdbdbdbdb,
    32'h1f1f1f1f, 32'h63636363, 32'ha7a7a7a7, 32'hebebebeb,
    32'h2f2f2f2f, 32'h73737373, 32'hb7b7b7b7, 32'hfbfbfbfb,
    32'h3f3f3f3f, 32'h83838383, 32'hc7c7c7c7, 32'h0b0b0b0b,
    32'h4f4f4f4f, 32'h93939393, 32'hd7d7d7d7, 32'h1b1b1b1b,
    32'h5f5f5f5f, 32'ha3a3a3a3, 32'he7e7e7e7, 32'h2b2b2b2b,
    32'h6f6f6f6f, 32'hb3b3b3b3, 32'hf7f7f7f7, 32'h3b3b3b3b,
    32'h7f7f7f7f, 32'hc3c3c3c3, 32'h07070707, 32'h4b4b4b4b,
    32'h8f8f8f8f, 32'hd3d3d3d3, 32'h17171717, 32'h5b5b5b5b,
    32'h9f9f9f9f, 32'he3e3e3e3, 32'h27272727, 32'h6b6b6b6b,
    32'hafafafaf, 32'hf3f3f3f3, 32'h37373737, 32'h7b7b7b7b,
    32'hbfbfbfbf, 32'h03030303, 32'h47474747, 32'h8b8b8b8b,
    32'hcfcfcfcf, 32'h13131313, 32'h57575757, 32'h9b9b9b9b,
    32'hdfdfdfdf, 32'h23232323, 32'h67676767, 32'habababab,
    32'hefefefef, 32'h33333333, 32'h77777777, 32'hbbbbbbbb,
    32'hffffffff, 32'h43434343, 32'h87878787, 32'hcbcbcbcb,
    32'h0f0f0f0f, 32'h53535353, 32'h97979797, 32'hdbdbdbdb,
    32'h1f1f1f1f, 32'h63636363, 32'ha7a7a7a7, 32'hebebebeb
  };

  function automatic hash_t gear_lookup(logic [7:0] b);
    hash_t g;
    g = '0;
    if (b[7:6] != 2'b11) begin
      g = GEAR_VALUES[b];
    end
    return g;
  endfunction

endpackage

FILE: hdl/mgc_cut_eval.sv
// Gear hash update and three-level cut decision for one data byte.
`timescale 1ns / 1ps

module mgc_cut_eval (
  input  mgc_pkg::hash_t     hash,
  input  mgc_pkg::length_t   length,
  input  mgc_pkg::in_word_t  word,
  input  mgc_pkg::cfg_regs_t cfg,
  output mgc_pkg::hash_t     hash_next,
  output mgc_pkg::length_t   len,
  output mgc_pkg::cut_dec_t  dec
);
  import mgc_pkg::*;

  // mask widens below avg, narrows past 1.5 * avg
  function automatic logic level_hit(hash_t h, logic [MASK_BITS-1:0] base,
                                     logic [CFG_BITS-1:0] ln,
                                     logic [CFG_BITS-1:0] avg);
    logic [CFG_BITS:0]    limit;
    logic [MASK_BITS-1:0] m;
    limit = {1'b0, avg} + {2'b00, avg[CFG_BITS-1:1]};
    if (ln < avg) begin
      m = {base[MASK_BITS-2:0], 1'b1};
    end else if ({1'b0, ln} > limit) begin
      m = base >> 1;
    end else begin
      m = base;
    end
    return (h[MASK_BITS-1:0] & m) == '0;
  endfunction

  logic [CFG_BITS-1:0]  len_c;
  logic [MASK_BITS-1:0] normal_mask;
  logic [MASK_BITS-1:0] small_mask;
  logic                 normal_hit;
  logic                 small_hit;
  logic                 micro_hit;
  logic                 len_limit;

  assign hash_next = {hash[HASH_BITS-2:0], 1'b0} ^ gear_lookup(word.data_byte);
  assign len       = length + length_t'(1);
  assign len_c     = CFG_BITS'(len);

  assign normal_mask = (len_c <= cfg.normal_avg_length) ? NORMAL_SHORT : NORMAL_LONG;
  assign small_mask  = (len_c <= cfg.small_avg_length) ? SMALL_SHORT : SMALL_LONG;

  assign normal_hit = (len_c >= cfg.normal_min_length) &&
                      level_hit(hash_next, normal_mask, len_c, cfg.normal_avg_length);
  assign small_hit  = (len_c >= cfg.small_min_length) &&
                      level_hit(hash_next, small_mask, len_c, cfg.small_avg_length);
  assign micro_hit  = (len_c >= cfg.micro_min_length) &&
                      level_hit(hash_next, MICRO_MASK, len_c, cfg.micro_avg_length);
  assign len_limit  = (len_c >= cfg.max_length) || (&len);

  always_comb begin
    dec.cut    = 1'b0;
    dec.level  = LEVEL_NORMAL;
    dec.reason = REASON_HASH;
    if (normal_hit) begin
      dec.cut   = 1'b1;
      dec.level = LEVEL_NORMAL;
    end else if (small_hit) begin
      dec.cut   = 1'b1;
      dec.level = LEVEL_SMALL;
    end else if (micro_hit) begin
      dec.cut   = 1'b1;
      dec.level = LEVEL_MICRO;
    end
    if (len_limit) begin
      dec.cut    = 1'b1;
      dec.level  = LEVEL_NORMAL;
      dec.reason = REASON_MAX;
    end else if (!dec.cut && word.end_of_data) begin
      dec.cut    = 1'b1;
      dec.level  = LEVEL_NORMAL;
      dec.reason = REASON_EOD;
    end
  end

endmodule

FILE: hdl/multilevel_gear_chunker.sv
// Multilevel gear-hash content-defined chunker, top level.
// Chunk words: the output register loads a chunk word when the byte that closes it leaves the input register.
// Throughput: one byte per cycle unless a chunk-closing byte waits on a stalled output, set by the update loop.
// Output register and input register decouple the two sides; a stalled output holds
// the input only while a chunk-closing byte waits in the input register.
// Reset: registers return to their default values, hash, length and start clear, no words held.
`timescale 1ns / 1ps

module multilevel_gear_chunker (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  mgc_pkg::in_word_t                    in_word,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output mgc_pkg::out_word_t                   out_word,
  input  logic                                 cfg_write,
  input  logic [mgc_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
  input  logic [mgc_pkg::CFG_BITS-1:0]         cfg_data
);
  import mgc_pkg::*;

  cfg_regs_t cfg;
  in_word_t  in_q;
  logic      in_valid_q;
  hash_t     hash;
  length_t   length;
  position_t start;

  hash_t    hash_next;
  length_t  len;
  cut_dec_t dec;
  logic     out_free;
  logic     advance;

  mgc_cut_eval u_eval (
    .hash      (hash),
    .length    (length),
    .word      (in_q),
    .cfg       (cfg),
    .hash_next (hash_next),
    .len       (len),
    .dec       (dec)
  );

  assign out_free = !out_valid || out_ready;
  assign advance  = in_valid_q && (!dec.cut || out_free);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.micro_min_length  <= 16'd512;
      cfg.micro_avg_length  <= 16'd1024;
      cfg.small_min_length  <= 16'd1024;
      cfg.small_avg_length  <= 16'd2048;
      cfg.normal_min_length <= 16'd2048;
      cfg.normal_avg_length <= 16'd4096;
      cfg.max_length        <= 16'd8192;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MICRO_MIN:  cfg.micro_min_length  <= cfg_data;
        REG_MICRO_AVG:  cfg.micro_avg_length  <= cfg_data;
        REG_SMALL_MIN:  cfg.small_min_length  <= cfg_data;
        REG_SMALL_AVG:  cfg.small_avg_length  <= cfg_data;
        REG_NORMAL_MIN: cfg.normal_min_length <= cfg_data;
        REG_NORMAL_AVG: cfg.normal_avg_length <= cfg_data;
        REG_MAX_LENGTH: cfg.max_length        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_q <= in_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hash   <= '0;
      length <= '0;
      start  <= '0;
    end else if (advance) begin
      if (!dec.cut) begin
        hash   <= hash_next;
        length <= len;
      end else if (in_q.end_of_data) begin
        hash   <= '0;
        length <= '0;
        start  <= '0;
      end else begin
        hash   <= '0;
        length <= '0;
        start  <= start + POSITION_BITS'(len);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && dec.cut) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && dec.cut) begin
      out_word.chunk_start  <= 48'(start);
      out_word.chunk_length <= 16'(len);
      out_word.chunk_level  <= dec.level;
      out_word.cut_reason   <= dec.reason;
    end
  end

  a_length_not_full: assert property (@(posedge clk) disable iff (rst)
    !(&length))
    else $error("open chunk length reached the counter limit");

  a_eod_clears: assert property (@(posedge clk) disable iff (rst)
    advance && in_q.end_of_data |=> start == '0 && length == '0 && hash == '0)
    else $error("state not cleared after end of data");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> in_valid_q && out_valid && !out_ready)
    else $error("input stalled without a blocked output word");

  a_forced_cut_level: assert property (@(posedge clk) disable iff (rst)
    advance && dec.cut && dec.reason != REASON_HASH |-> dec.level == LEVEL_NORMAL)
    else $error("forced cut not at normal level");

endmodule

FILE: test/chunk_boundary_checker.sv
// Checker for the gear chunker: predicts chunk words from accepted bytes and compares them.
`timescale 1ns / 1ps

module chunk_boundary_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_ready,
  input  mgc_pkg::in_word_t                  in_word,
  input  logic                               out_valid,
  input  logic                               out_ready,
  input  mgc_pkg::out_word_t                 out_word,
  input  logic                               cfg_write,
  input  logic [mgc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [mgc_pkg::CFG_BITS-1:0]       cfg_data,
  output int                                 errors,
  output int                                 pending,
  output int                                 hash_cuts,
  output int                                 max_cuts,
  output int                                 eod_cuts
);
  import mgc_pkg::*;

  localparam cfg_regs_t CFG_RESET = {16'd512, 16'd1024, 16'd1024, 16'd2048,
                                     16'd2048, 16'd4096, 16'd8192};

  cfg_regs_t regs = CFG_RESET;
  hash_t     gear = '0;
  length_t   run_len = '0;
  position_t run_start = '0;
  out_word_t expected_chunks [$];
  int        err_count = 0;
  int        words_seen = 0;
  int        n_hash = 0;
  int        n_max = 0;
  int        n_eod = 0;

  function automatic hash_t gear_value(logic [7:0] b);
    hash_t g;
    g = '0;
    if (b < 8'd192) begin
      g = GEAR_VALUES[b];
    end
    return g;
  endfunction

  // mask widens below the average, narrows past 1.5x the average
  function automatic bit boundary(hash_t h, logic [MASK_BITS-1:0] mask, length_t len,
                                  logic [CFG_BITS-1:0] avg);
    int unsigned m;
    int unsigned l;
    int unsigned a;
    m = mask;
    l = len;
    a = avg;
    if (l < a) begin
      m = (m << 1) | 1;
    end else if (l > (a * 3) / 2) begin
      m = m >> 1;
    end
    return (h & m) == 0;
  endfunction

  task automatic report(string msg);
    if (err_count < 40) begin
      $display("%0t: %s", $realtime, msg);
    end
    err_count++;
  endtask

  task automatic take_byte(in_word_t w);
    length_t   len;
    bit        cut;
    level_t    lvl;
    reason_t   why;
    out_word_t chunk;
    gear = (gear << 1) ^ gear_value(w.data_byte);
    len = run_len + 1'b1;
    cut = 1'b0;
    lvl = LEVEL_NORMAL;
    why = REASON_HASH;
    if (len >= regs.normal_min_length &&
        boundary(gear, (len <= regs.normal_avg_length) ? NORMAL_SHORT : NORMAL_LONG,
                 len, regs.normal_avg_length)) begin
      cut = 1'b1;
    end else if (len >= regs.small_min_length &&
                 boundary(gear, (len <= regs.small_avg_length) ? SMALL_SHORT : SMALL_LONG,
                          len, regs.small_avg_length)) begin
      cut = 1'b1;
      lvl = LEVEL_SMALL;
    end else if (len >= regs.micro_min_length &&
                 boundary(gear, MICRO_MASK, len, regs.micro_avg_length)) begin
      cut = 1'b1;
      lvl = LEVEL_MICRO;
    end
    // max length, or a full length counter, overrides any hash cut
    if (len >= regs.max_length || len == '1) begin
      cut = 1'b1;
      lvl = LEVEL_NORMAL;
      why = REASON_MAX;
    end
    if (!cut && w.end_of_data) begin
      cut = 1'b1;
      why = REASON_EOD;
    end
    if (!cut) begin
      run_len = len;
    end else begin
      chunk.chunk_start = run_start;
      chunk.chunk_length = len;
      chunk.chunk_level = lvl;
      chunk.cut_reason = why;
      expected_chunks = {expected_chunks, chunk};
      run_start = w.end_of_data ? '0 : run_start + len;
      run_len = '0;
      gear = '0;
    end
  endtask

  task automatic check_word(out_word_t got);
    out_word_t want;
    if (expected_chunks.size() == 0) begin
      report($sformatf("unexpected word: start %0d length %0d level %0d reason %0d",
                       got.chunk_start, got.chunk_length, got.chunk_level, got.cut_reason));
      return;
    end
    want = expected_chunks.pop_front();
    if (got.chunk_start != want.chunk_start) begin
      report($sformatf("word %0d: start %0d, expected %0d",
                       words_seen, got.chunk_start, want.chunk_start));
    end
    if (got.chunk_length != want.chunk_length) begin
      report($sformatf("word %0d: length %0d, expected %0d",
                       words_seen, got.chunk_length, want.chunk_length));
    end
    if (got.chunk_level != want.chunk_level) begin
      report($sformatf("word %0d: level %0d, expected %0d",
                       words_seen, got.chunk_level, want.chunk_level));
    end
    if (got.cut_reason != want.cut_reason) begin
      report($sformatf("word %0d: reason %0d, expected %0d",
                       words_seen, got.cut_reason, want.cut_reason));
    end
    case (want.cut_reason)
      REASON_HASH: n_hash++;
      REASON_MAX:  n_max++;
      default:     n_eod++;
    endcase
    words_seen++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      regs = CFG_RESET;
      gear = '0;
      run_len = '0;
      run_start = '0;
      expected_chunks.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_MICRO_MIN:  regs.micro_min_length = cfg_data;
          REG_MICRO_AVG:  regs.micro_avg_length = cfg_data;
          REG_SMALL_MIN:  regs.small_min_length = cfg_data;
          REG_SMALL_AVG:  regs.small_avg_length = cfg_data;
          REG_NORMAL_MIN: regs.normal_min_length = cfg_data;
          REG_NORMAL_AVG: regs.normal_avg_length = cfg_data;
          REG_MAX_LENGTH: regs.max_length = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        take_byte(in_word);
      end
      if (out_valid && out_ready) begin
        check_word(out_word);
      end
    end
    errors <= err_count;
    pending <= expected_chunks.size();
    hash_cuts <= n_hash;
    max_cuts <= n_max;
    eod_cuts <= n_eod;
  end

endmodule

FILE: test/tb.sv
// Testbench top for the multilevel gear chunker: stimulus, idling and verdict.
`timescale 1ns / 1ps

module tb;
  import mgc_pkg::*;

  localparam int LIMIT = 1_000_000;
  localparam int DRAIN = 8;
  localparam int PHASES = 10;
  localparam int PHASE_BYTES = 150;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UNUSED = 3'd7;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  in_word_t                  in_word;
  logic                      out_valid;
  logic                      out_ready;
  out_word_t                 out_word;
  logic                      cfg_write;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0]       cfg_data;

  int errors;
  int pending;
  int hash_cuts;
  int max_cuts;
  int eod_cuts;
  int cycle_count = 0;
  int bytes_sent = 0;
  int settings_used = 1;
  bit quiet = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  multilevel_gear_chunker dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  chunk_boundary_checker chk (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending),
    .hash_cuts (hash_cuts),
    .max_cuts  (max_cuts),
    .eod_cuts  (eod_cuts)
  );

  function automatic int idle_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end
    if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [CFG_BITS-1:0] pick_reg(int lo, int hi);
    int r;
    r = $urandom_range(0, 24);
    if (r == 0) begin
      return 16'hFFFF;
    end
    if (r == 1) begin
      return 16'd0;
    end
    if (r == 2) begin
      return 16'd1;
    end
    return 16'($urandom_range(lo, hi));
  endfunction

  function automatic cfg_regs_t random_settings();
    cfg_regs_t s;
    s.micro_min_length = pick_reg(0, 16);
    s.micro_avg_length = pick_reg(1, 32);
    s.small_min_length = pick_reg(0, 48);
    s.small_avg_length = pick_reg(1, 96);
    s.normal_min_length = pick_reg(0, 96);
    s.normal_avg_length = pick_reg(1, 192);
    s.max_length = pick_reg(24, 300);
    return s;
  endfunction

  function automatic cfg_regs_t uniform(logic [CFG_BITS-1:0] v);
    return {7{v}};
  endfunction

  task automatic put_reg(input logic [CFG_INDEX_BITS-1:0] idx, input logic [CFG_BITS-1:0] v);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
  endtask

  task automatic load_settings(input cfg_regs_t s, input bit stray);
    if (stray) begin
      put_reg(REG_UNUSED, 16'($urandom));
    end
    put_reg(REG_MICRO_MIN, s.micro_min_length);
    put_reg(REG_MICRO_AVG, s.micro_avg_length);
    put_reg(REG_SMALL_MIN, s.small_min_length);
    put_reg(REG_SMALL_AVG, s.small_avg_length);
    put_reg(REG_NORMAL_MIN, s.normal_min_length);
    put_reg(REG_NORMAL_AVG, s.normal_avg_length);
    put_reg(REG_MAX_LENGTH, s.max_length);
    cfg_write <= 1'b0;
    settings_used++;
  endtask

  // valid stays up across back-to-back words; dropped only for a gap
  task automatic send_byte(input logic [7:0] b, input logic eod);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= {b, eod};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // mostly random bytes closed by a run of zero-gear bytes, which clears low hash bits
  task automatic send_segment();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    if (kind < 70) begin
      n = $urandom_range(0, 40);
      repeat (n) send_byte(8'($urandom), 1'b0);
      n = $urandom_range(6, 14);
      repeat (n) send_byte(8'($urandom_range(192, 255)), 1'b0);
    end else if (kind < 88) begin
      n = $urandom_range(1, 20);
      repeat (n) send_byte(8'($urandom), $urandom_range(0, 49) == 0);
    end else begin
      send_byte(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      stall = idle_gap();
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count == LIMIT);
    $display("Timeout after %0d cycles", LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    cfg_regs_t s;
    int first;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings; end of data closes the stream and the next one starts at 0
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(8'hBF, 1'b1);
    send_byte(8'h01, 1'b1);
    settle();

    // all zero: every byte is cut at max length
    load_settings(uniform(16'd0), 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b0);
    send_byte(8'hAA, 1'b1);
    settle();

    // micro level only, max length at the top
    s = uniform(16'hFFFF);
    s.micro_min_length = 16'd1;
    s.micro_avg_length = 16'd1;
    load_settings(s, 1'b0);
    send_byte(8'hC0, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hFF, 1'b1);
    settle();

    // small beats micro, then normal beats both
    s.small_min_length = 16'd1;
    s.small_avg_length = 16'd1;
    load_settings(s, 1'b0);
    send_byte(8'hE0, 1'b0);
    settle();
    s.normal_min_length = 16'd1;
    s.normal_avg_length = 16'd1;
    load_settings(s, 1'b0);
    send_byte(8'hF0, 1'b0);
    settle();

    // hash boundary and max length on the same byte
    s.max_length = 16'd1;
    load_settings(s, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      quiet = (p % 4 == 3);
      load_settings(random_settings(), p % 3 == 0);
      first = bytes_sent;
      while (bytes_sent - first < PHASE_BYTES) send_segment();
      settle();
    end

    $display("Run: %0d bytes under %0d register settings, %0d chunk words checked",
             bytes_sent, settings_used, hash_cuts + max_cuts + eod_cuts);
    $display("Cuts: %0d at hash boundaries, %0d at max length, %0d at end of data",
             hash_cuts, max_cuts, eod_cuts);
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
